[rtl/core/esp_pkg.sv]
package esp_pkg;

    localparam int COUNT_W   = 16;
    localparam int SPEED_W   = 29;
    localparam int ERR_W     = 30;
    localparam int GAIN_W    = 16;
    localparam int TARGET_W  = 9;
    localparam int FRAC_W    = 16;
    localparam int COEF_W    = 28;
    localparam int PROD_W    = ERR_W + COEF_W;
    localparam int SUM_W     = 60;
    localparam int DIV_W     = SUM_W;
    localparam int DIV_DIGIT = 4;
    localparam int DIV_STEPS = DIV_W / DIV_DIGIT;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int REM_W     = 6;
    localparam int QUO_W     = 53;
    localparam int UPD_W     = QUO_W + 1;
    localparam int ACC_W     = 49;
    localparam int MAG_W     = ACC_W - 1 - FRAC_W;
    localparam int DUTY_W    = 13;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam int DUTY_LIMIT = 7199;

    localparam logic [COUNT_W-1:0] FOLD_THRESHOLD = 16'd64000;
    localparam logic [COUNT_W-1:0] FOLD_MAX       = 16'hFFFF;
    localparam logic [12:0]        SPEED_SCALE    = 13'd6005;
    localparam logic [REM_W:0]     DIVISOR        = 7'd40;

    localparam logic signed [UPD_W-1:0] ACC_MAX = 54'sd140737488355328;
    localparam logic signed [UPD_W-1:0] ACC_MIN = -54'sd140737488355328;

    localparam logic [CFG_IDX_W-1:0] CFG_RUN_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_TARGET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D       = 3'd4;

    localparam logic signed [TARGET_W-1:0] RST_TARGET = 9'sd2;
    localparam logic [GAIN_W-1:0]          RST_KP     = 16'd950;
    localparam logic [GAIN_W-1:0]          RST_KI     = 16'd830;
    localparam logic [GAIN_W-1:0]          RST_KD     = 16'd320;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPEED,
        ST_ERR,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_C,
        ST_SUM,
        ST_DIV_GO,
        ST_DIV,
        ST_UPD,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        MS_SPEED,
        MS_CUR,
        MS_PREV,
        MS_PREV2
    } t_mul_sel;

    typedef struct packed {
        t_mul_sel mul_sel;
        logic     prod_load;
        logic     sum_clr;
        logic     sum_add;
        logic     err_load;
        logic     div_start;
        logic     acc_update;
        logic     out_load;
    } t_ctl;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

[rtl/core/esp_div40.sv]
module esp_div40 (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  esp_pkg::t_div_req i_req,
    output esp_pkg::t_div_rsp o_rsp
);

    localparam logic [esp_pkg::DIV_CNT_W-1:0] LAST =
        esp_pkg::DIV_CNT_W'(esp_pkg::DIV_STEPS - 1);

    logic                          r_busy;
    logic                          r_done;
    logic [esp_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [esp_pkg::REM_W-1:0]     r_rem;
    logic [esp_pkg::DIV_W-1:0]     r_work;
    logic [esp_pkg::REM_W-1:0]     n_rem;
    logic [esp_pkg::DIV_W-1:0]     n_work;

    // four restoring steps per cycle, remainder stays below the divisor
    always_comb begin
        logic [esp_pkg::REM_W:0]       trial;
        logic [esp_pkg::REM_W-1:0]     rem;
        logic [esp_pkg::DIV_DIGIT-1:0] digit;
        rem   = r_rem;
        digit = '0;
        trial = '0;
        for (int k = 0; k < esp_pkg::DIV_DIGIT; k++) begin
            trial = {rem, r_work[esp_pkg::DIV_W-1-k]};
            if (trial >= esp_pkg::DIVISOR) begin
                rem = esp_pkg::REM_W'(trial - esp_pkg::DIVISOR);
                digit[esp_pkg::DIV_DIGIT-1-k] = 1'b1;
            end else begin
                rem = trial[esp_pkg::REM_W-1:0];
            end
        end
        n_rem  = rem;
        n_work = {r_work[esp_pkg::DIV_W-1-esp_pkg::DIV_DIGIT:0], digit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= '0;
            r_work <= i_req.dividend;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_work <= n_work;
        end
    end

    assign o_rsp = '{done: r_done, quotient: r_work};

endmodule

[rtl/core/encoder_speed_pid_pwm.sv]
// Encoder speed loop: each accepted word is one encoder count per 50 ms tick; the block folds
// reverse counts, converts the count to an unsigned Q13.16 speed, runs a Tustin incremental
// PID on the error and returns one word with the limited PWM duty, its limit and sign flags
// and the speed. One signed multiplier (30 x 28 bits) serves the speed scaling and the three
// PID terms, and the increment is divided by 40 in a separate unit that retires four quotient
// bits a cycle; the result is registered. When the controller is disabled the PID steps are
// skipped and the duty and flags are zero. Only one word is in work at a time; the next is
// taken as soon as the result sits in the output register, even if it has not yet been
// taken. Configuration writes are always ready and must only be issued while the block is
// idle.
module encoder_speed_pid_pwm (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [esp_pkg::COUNT_W-1:0]    i_encoder_count,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [esp_pkg::DUTY_W-1:0]     o_pwm_duty,
    output logic                           o_duty_limited,
    output logic                           o_demand_negative,
    output logic [esp_pkg::SPEED_W-1:0]    o_measured_speed,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [esp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [esp_pkg::CFG_DAT_W-1:0]  i_cfg_data
);

    esp_pkg::t_state   r_state;
    esp_pkg::t_state   n_state;
    esp_pkg::t_ctl     w_ctl;
    esp_pkg::t_div_req w_div_req;
    esp_pkg::t_div_rsp w_div_rsp;

    logic                                  r_run_en;
    logic signed [esp_pkg::TARGET_W-1:0]   r_target;
    logic [esp_pkg::GAIN_W-1:0]            r_kp;
    logic [esp_pkg::GAIN_W-1:0]            r_ki;
    logic [esp_pkg::GAIN_W-1:0]            r_kd;

    logic [esp_pkg::COUNT_W-1:0]           r_count;
    logic signed [esp_pkg::COEF_W-1:0]     r_ca;
    logic signed [esp_pkg::COEF_W-1:0]     r_cb;
    logic signed [esp_pkg::COEF_W-1:0]     r_cc;
    logic [esp_pkg::SPEED_W-1:0]           r_speed;
    logic signed [esp_pkg::ERR_W-1:0]      r_err;
    logic signed [esp_pkg::ERR_W-1:0]      r_e1;
    logic signed [esp_pkg::ERR_W-1:0]      r_e2;
    logic signed [esp_pkg::PROD_W-1:0]     r_prod;
    logic signed [esp_pkg::SUM_W-1:0]      r_sum;
    logic                                  r_div_neg;
    logic signed [esp_pkg::ACC_W-1:0]      r_acc;

    logic                                  r_out_valid;
    logic [esp_pkg::DUTY_W-1:0]            r_pwm_duty;
    logic                                  r_duty_limited;
    logic                                  r_demand_negative;
    logic [esp_pkg::SPEED_W-1:0]           r_measured_speed;

    logic                                  w_accept;
    logic                                  w_out_free;
    logic [esp_pkg::COUNT_W-1:0]           w_fold;
    logic signed [esp_pkg::COEF_W-1:0]     w_kp;
    logic signed [esp_pkg::COEF_W-1:0]     w_ki;
    logic signed [esp_pkg::COEF_W-1:0]     w_kd;
    logic signed [esp_pkg::COEF_W-1:0]     w_ca;
    logic signed [esp_pkg::COEF_W-1:0]     w_cb;
    logic signed [esp_pkg::COEF_W-1:0]     w_cc;
    logic signed [esp_pkg::ERR_W-1:0]      w_mul_a;
    logic signed [esp_pkg::COEF_W-1:0]     w_mul_b;
    logic signed [esp_pkg::PROD_W-1:0]     w_prod;
    logic signed [esp_pkg::ERR_W-1:0]      w_err;
    logic signed [esp_pkg::UPD_W-1:0]      w_quo;
    logic signed [esp_pkg::UPD_W-1:0]      w_inc;
    logic signed [esp_pkg::UPD_W-1:0]      w_u;
    logic signed [esp_pkg::UPD_W-1:0]      w_u_sat;
    logic signed [esp_pkg::ACC_W-1:0]      w_abs;
    logic [esp_pkg::MAG_W-1:0]             w_mag;
    logic                                  w_lim;

    assign o_in_stall  = (r_state != esp_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    assign w_fold = (i_encoder_count > esp_pkg::FOLD_THRESHOLD) ?
                    esp_pkg::FOLD_MAX - i_encoder_count : i_encoder_count;

    assign w_kp = $signed(esp_pkg::COEF_W'(r_kp));
    assign w_ki = $signed(esp_pkg::COEF_W'(r_ki));
    assign w_kd = $signed(esp_pkg::COEF_W'(r_kd));
    assign w_ca = (w_kp <<< 5) + (w_kp <<< 3) + w_ki
                + (w_kd <<< 9) + (w_kd <<< 8) + (w_kd <<< 5);
    assign w_cb = w_ki - (w_kd <<< 10) - (w_kd <<< 9) - (w_kd <<< 6)
                - (w_kp <<< 5) - (w_kp <<< 3);
    assign w_cc = (w_kd <<< 9) + (w_kd <<< 8) + (w_kd <<< 5);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            esp_pkg::ST_IDLE:   if (w_accept) n_state = esp_pkg::ST_SPEED;
            esp_pkg::ST_SPEED:  n_state = esp_pkg::ST_ERR;
            esp_pkg::ST_ERR:    n_state = r_run_en ? esp_pkg::ST_MUL_A : esp_pkg::ST_DONE;
            esp_pkg::ST_MUL_A:  n_state = esp_pkg::ST_MUL_B;
            esp_pkg::ST_MUL_B:  n_state = esp_pkg::ST_MUL_C;
            esp_pkg::ST_MUL_C:  n_state = esp_pkg::ST_SUM;
            esp_pkg::ST_SUM:    n_state = esp_pkg::ST_DIV_GO;
            esp_pkg::ST_DIV_GO: n_state = esp_pkg::ST_DIV;
            esp_pkg::ST_DIV:    if (w_div_rsp.done) n_state = esp_pkg::ST_UPD;
            esp_pkg::ST_UPD:    n_state = esp_pkg::ST_DONE;
            esp_pkg::ST_DONE:   if (w_out_free) n_state = esp_pkg::ST_IDLE;
            default:            n_state = esp_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        w_ctl = '{mul_sel: esp_pkg::MS_SPEED, default: 1'b0};
        unique case (r_state)
            esp_pkg::ST_SPEED: begin
                w_ctl.mul_sel   = esp_pkg::MS_SPEED;
                w_ctl.prod_load = 1'b1;
            end
            esp_pkg::ST_ERR: begin
                w_ctl.err_load = 1'b1;
            end
            esp_pkg::ST_MUL_A: begin
                w_ctl.mul_sel   = esp_pkg::MS_CUR;
                w_ctl.prod_load = 1'b1;
            end
            esp_pkg::ST_MUL_B: begin
                w_ctl.mul_sel   = esp_pkg::MS_PREV;
                w_ctl.prod_load = 1'b1;
                w_ctl.sum_clr   = 1'b1;
            end
            esp_pkg::ST_MUL_C: begin
                w_ctl.mul_sel   = esp_pkg::MS_PREV2;
                w_ctl.prod_load = 1'b1;
                w_ctl.sum_add   = 1'b1;
            end
            esp_pkg::ST_SUM: begin
                w_ctl.sum_add = 1'b1;
            end
            esp_pkg::ST_DIV_GO: begin
                w_ctl.div_start = 1'b1;
            end
            esp_pkg::ST_UPD: begin
                w_ctl.acc_update = 1'b1;
            end
            esp_pkg::ST_DONE: begin
                w_ctl.out_load = w_out_free;
            end
            default: begin
                w_ctl.prod_load = 1'b0;
            end
        endcase
    end

    always_comb begin
        unique case (w_ctl.mul_sel)
            esp_pkg::MS_SPEED: begin
                w_mul_a = $signed(esp_pkg::ERR_W'(r_count));
                w_mul_b = $signed(esp_pkg::COEF_W'(esp_pkg::SPEED_SCALE));
            end
            esp_pkg::MS_CUR: begin
                w_mul_a = r_err;
                w_mul_b = r_ca;
            end
            esp_pkg::MS_PREV: begin
                w_mul_a = r_e1;
                w_mul_b = r_cb;
            end
            esp_pkg::MS_PREV2: begin
                w_mul_a = r_e2;
                w_mul_b = r_cc;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    assign w_err = esp_pkg::ERR_W'($signed({r_target, {esp_pkg::FRAC_W{1'b0}}}))
                 - $signed(esp_pkg::ERR_W'(r_prod[esp_pkg::SPEED_W-1:0]));

    assign w_div_req = '{
        start:    w_ctl.div_start,
        dividend: r_sum[esp_pkg::SUM_W-1] ? esp_pkg::DIV_W'(-r_sum) : esp_pkg::DIV_W'(r_sum)
    };

    esp_div40 u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign w_quo   = $signed({1'b0, w_div_rsp.quotient[esp_pkg::QUO_W-1:0]});
    assign w_inc   = r_div_neg ? -w_quo : w_quo;
    assign w_u     = esp_pkg::UPD_W'(r_acc) + w_inc;
    assign w_u_sat = (w_u > esp_pkg::ACC_MAX) ? esp_pkg::ACC_MAX :
                     (w_u < esp_pkg::ACC_MIN) ? esp_pkg::ACC_MIN : w_u;

    assign w_abs = r_acc[esp_pkg::ACC_W-1] ? -r_acc : r_acc;
    assign w_mag = w_abs[esp_pkg::ACC_W-2:esp_pkg::FRAC_W];
    assign w_lim = w_mag > esp_pkg::MAG_W'(esp_pkg::DUTY_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= esp_pkg::ST_IDLE;
            r_run_en    <= 1'b0;
            r_target    <= esp_pkg::RST_TARGET;
            r_kp        <= esp_pkg::RST_KP;
            r_ki        <= esp_pkg::RST_KI;
            r_kd        <= esp_pkg::RST_KD;
            r_acc       <= '0;
            r_e1        <= '0;
            r_e2        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    esp_pkg::CFG_RUN_ENABLE:   r_run_en <= i_cfg_data[0];
                    esp_pkg::CFG_SPEED_TARGET: r_target <= $signed(i_cfg_data[esp_pkg::TARGET_W-1:0]);
                    esp_pkg::CFG_GAIN_P:       r_kp     <= i_cfg_data;
                    esp_pkg::CFG_GAIN_I:       r_ki     <= i_cfg_data;
                    esp_pkg::CFG_GAIN_D:       r_kd     <= i_cfg_data;
                    default:                   r_run_en <= r_run_en;
                endcase
            end
            if (w_ctl.acc_update) begin
                r_acc <= esp_pkg::ACC_W'(w_u_sat);
                r_e2  <= r_e1;
                r_e1  <= r_err;
            end
            if (w_ctl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_count <= w_fold;
            r_ca    <= w_ca;
            r_cb    <= w_cb;
            r_cc    <= w_cc;
        end
        if (w_ctl.prod_load) begin
            r_prod <= w_prod;
        end
        if (w_ctl.err_load) begin
            r_speed <= r_prod[esp_pkg::SPEED_W-1:0];
            r_err   <= w_err;
        end
        if (w_ctl.sum_clr) begin
            r_sum <= esp_pkg::SUM_W'(r_prod);
        end else if (w_ctl.sum_add) begin
            r_sum <= r_sum + esp_pkg::SUM_W'(r_prod);
        end
        if (w_ctl.div_start) begin
            r_div_neg <= r_sum[esp_pkg::SUM_W-1];
        end
        if (w_ctl.out_load) begin
            r_measured_speed <= r_speed;
            if (r_run_en) begin
                r_pwm_duty        <= w_lim ? esp_pkg::DUTY_W'(esp_pkg::DUTY_LIMIT)
                                           : w_mag[esp_pkg::DUTY_W-1:0];
                r_duty_limited    <= w_lim;
                r_demand_negative <= r_acc[esp_pkg::ACC_W-1];
            end else begin
                r_pwm_duty        <= '0;
                r_duty_limited    <= 1'b0;
                r_demand_negative <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_pwm_duty        = r_pwm_duty;
    assign o_duty_limited    = r_duty_limited;
    assign o_demand_negative = r_demand_negative;
    assign o_measured_speed  = r_measured_speed;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("block ready straight after taking a word");

    a_acc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acc <= esp_pkg::ACC_W'(esp_pkg::ACC_MAX)) &&
        (r_acc >= esp_pkg::ACC_W'(esp_pkg::ACC_MIN)))
        else $error("output accumulator outside saturation range");

    a_duty_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_duty_limited) |->
        (o_pwm_duty == esp_pkg::DUTY_W'(esp_pkg::DUTY_LIMIT)))
        else $error("limited duty not at the limit value");

    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == esp_pkg::ST_DIV))
        else $error("divider finished outside its wait state");

endmodule
